[hdl/rhc_pkg.sv]
// Shared types, widths and a helper function for the RGB to HSV converter.
// Depends on nothing; the front end, back end, top and testbench refer to it by scoped names.
package rhc_pkg;

    // Field widths of the pixel and of the result.
    localparam int CH_W      = 8;
    localparam int HUE_W     = 9;
    localparam int PCT_W     = 7;

    // Widths of the hue numerator (0..360*255-60) and saturation numerator (0..100*255).
    localparam int HUE_NUM_W = 17;
    localparam int SAT_NUM_W = 15;

    // Default queue depths.
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 16;

    // Classified work for one pixel, passed from the front to the back.
    typedef struct packed {
        logic [HUE_NUM_W-1:0] hue_num;
        logic [CH_W-1:0]      hue_div;
        logic [SAT_NUM_W-1:0] sat_num;
        logic [CH_W-1:0]      sat_div;
        logic [CH_W-1:0]      max_ch;
    } rhc_work_t;

    // One finished result beat.
    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] saturation;
        logic [PCT_W-1:0] brightness;
    } rhc_result_t;

    // floor(100 * mx / 255), using the exact identity
    // floor(x / 255) = (x + 1 + (x >> 8)) >> 8 for x below 65535.
    function automatic logic [PCT_W-1:0] brightness_pct(input logic [CH_W-1:0] mx);
        logic [SAT_NUM_W:0] prod;
        logic [SAT_NUM_W:0] sum;
        begin
            prod = (SAT_NUM_W + 1)'(mx) * (SAT_NUM_W + 1)'(100);
            sum  = prod + (SAT_NUM_W + 1)'(1) + (prod >> 8);
            brightness_pct = PCT_W'(sum >> 8);
        end
    endfunction

endpackage

[hdl/rhc_fifo.sv]
// Small synchronous queue built from registers, with a fill count.
// Depends on nothing; used for the queue between front and back and for the result queue.
module rhc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    // Handshake qualification.
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_reg[rd_ptr_reg];
    assign count   = count_reg;

    // Pointer and count update, wrapping at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[hdl/rhc_front.sv]
// Front end: accepts pixels, finds max, min and sector, and forms the division operands.
// Depends on rhc_pkg; feeds the queue in front of the back end.
module rhc_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [rhc_pkg::CH_W-1:0]  red,
    input  logic [rhc_pkg::CH_W-1:0]  green,
    input  logic [rhc_pkg::CH_W-1:0]  blue,
    output logic                      work_valid,
    output rhc_pkg::rhc_work_t        work,
    input  logic                      work_full
);

    localparam int CH_W  = rhc_pkg::CH_W;
    localparam int NUM_W = rhc_pkg::HUE_NUM_W + 2;

    logic               valid_reg, valid_next;
    rhc_pkg::rhc_work_t work_reg, work_next;
    logic               accept;
    logic               hand_off;

    logic [CH_W-1:0]         mx;
    logic [CH_W-1:0]         mn;
    logic [CH_W-1:0]         delta;
    logic signed [CH_W:0]    diff;
    logic signed [NUM_W-1:0] delta_s;
    logic signed [NUM_W-1:0] base;
    logic signed [NUM_W-1:0] num;

    // The stage is free when empty or when its beat moves on this cycle.
    assign hand_off   = valid_reg && !work_full;
    assign full       = valid_reg && work_full;
    assign accept     = push && !full;
    assign work_valid = valid_reg;
    assign work       = work_reg;

    // Classify the pixel: red wins ties over green, green over blue.
    always_comb
    begin
        mx = red;
        mn = red;
        if (green > mx) mx = green;
        if (blue > mx)  mx = blue;
        if (green < mn) mn = green;
        if (blue < mn)  mn = blue;
        delta   = mx - mn;
        delta_s = $signed({{(NUM_W - CH_W){1'b0}}, delta});

        if (red >= green && red >= blue)
        begin
            diff = $signed({1'b0, green}) - $signed({1'b0, blue});
            base = '0;
        end
        else if (green >= blue)
        begin
            diff = $signed({1'b0, blue}) - $signed({1'b0, red});
            base = delta_s * NUM_W'(120);
        end
        else
        begin
            diff = $signed({1'b0, red}) - $signed({1'b0, green});
            base = delta_s * NUM_W'(240);
        end

        // A negative angle wraps by one full turn.
        num = NUM_W'(diff) * NUM_W'(60) + base;
        if (num < 0)
        begin
            num = num + delta_s * NUM_W'(360);
        end

        // A zero divisor only arises with a zero numerator; divide by one instead.
        work_next.hue_num = rhc_pkg::HUE_NUM_W'(num);
        work_next.hue_div = (delta == '0) ? CH_W'(1) : delta;
        work_next.sat_num = rhc_pkg::SAT_NUM_W'(delta) * rhc_pkg::SAT_NUM_W'(100);
        work_next.sat_div = (mx == '0) ? CH_W'(1) : mx;
        work_next.max_ch  = mx;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (hand_off)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            work_reg <= work_next;
        end
    end

endmodule

[hdl/rhc_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, one division per cycle.
// Depends on nothing; the back end uses one for hue and one for saturation.
module rhc_div_pipe #(
    parameter int NUM_W = 17,
    parameter int DIV_W = 8,
    parameter int QUO_W = 9
) (
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DIV_W-1:0] div,
    output logic [QUO_W-1:0] quo
);

    // Compare width covers both the dividend and the most shifted divisor.
    localparam int SW = (NUM_W > DIV_W + QUO_W) ? NUM_W : DIV_W + QUO_W;

    logic [SW-1:0]    rem_reg [QUO_W];
    logic [SW-1:0]    rem_next [QUO_W];
    logic [DIV_W-1:0] div_reg [QUO_W];
    logic [DIV_W-1:0] div_next [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic [QUO_W-1:0] quo_next [QUO_W];

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        localparam int SH = QUO_W - 1 - k;

        logic [SW-1:0]    rem_in;
        logic [DIV_W-1:0] div_in;
        logic [QUO_W-1:0] quo_in;
        logic [SW-1:0]    shifted;

        // Stage inputs come from the ports or from the previous stage.
        if (k == 0)
        begin : g_first
            assign rem_in = SW'(num);
            assign div_in = div;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign div_in = div_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        // Try to take the divisor shifted to this bit out of the remainder.
        always_comb
        begin
            shifted     = SW'(div_in) << SH;
            div_next[k] = div_in;
            if (rem_in >= shifted)
            begin
                rem_next[k] = rem_in - shifted;
                quo_next[k] = quo_in | (QUO_W'(1) << SH);
            end
            else
            begin
                rem_next[k] = rem_in;
                quo_next[k] = quo_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next[k];
            div_reg[k] <= div_next[k];
            quo_reg[k] <= quo_next[k];
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule

[hdl/rhc_back.sv]
// Back end: draws work from the middle queue and runs the two divisions in step.
// Depends on rhc_pkg and rhc_div_pipe; issues only with room reserved in the result queue.
module rhc_back #(
    parameter int OUT_DEPTH = rhc_pkg::OUT_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           work_empty,
    input  rhc_pkg::rhc_work_t             work,
    output logic                           work_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
    output logic                           res_push,
    output rhc_pkg::rhc_result_t           res
);

    localparam int LAT   = rhc_pkg::HUE_W;
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);
    localparam int PCT_W = rhc_pkg::PCT_W;

    logic [LAT-1:0]   vld_reg, vld_next;
    logic [PCT_W-1:0] bright_reg [LAT];
    logic [PCT_W-1:0] bright_next [LAT];
    logic [CNT_W-1:0] inflight_reg, inflight_next;
    logic [CNT_W:0]   committed;
    logic [LAT-1:0]   hue_quo;
    logic [LAT-1:0]   sat_quo;

    // Issue only when every beat in flight and queued still fits.
    assign committed = {1'b0, out_count} + {1'b0, inflight_reg};
    assign work_pop  = !work_empty && (committed < (CNT_W + 1)'(OUT_DEPTH));
    assign res_push  = vld_reg[LAT-1];

    // Valid bits and brightness travel alongside the divider stages.
    always_comb
    begin
        vld_next = {vld_reg[LAT-2:0], work_pop};
        bright_next[0] = rhc_pkg::brightness_pct(work.max_ch);
        for (int i = 1; i < LAT; i++)
        begin
            bright_next[i] = bright_reg[i-1];
        end
    end

    // Count of beats inside the divider pipeline.
    always_comb
    begin
        inflight_next = inflight_reg;
        if (work_pop && !res_push)
        begin
            inflight_next = inflight_reg + CNT_W'(1);
        end
        else if (res_push && !work_pop)
        begin
            inflight_next = inflight_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            inflight_reg <= '0;
        end
        else
        begin
            vld_reg      <= vld_next;
            inflight_reg <= inflight_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LAT; i++)
        begin
            bright_reg[i] <= bright_next[i];
        end
    end

    // Hue = numerator / delta.
    rhc_div_pipe #(
        .NUM_W (rhc_pkg::HUE_NUM_W),
        .DIV_W (rhc_pkg::CH_W),
        .QUO_W (LAT)
    ) u_hue_div (
        .clk (clk),
        .num (work.hue_num),
        .div (work.hue_div),
        .quo (hue_quo)
    );

    // Saturation = 100 * delta / max, with the same latency as hue.
    rhc_div_pipe #(
        .NUM_W (rhc_pkg::SAT_NUM_W),
        .DIV_W (rhc_pkg::CH_W),
        .QUO_W (LAT)
    ) u_sat_div (
        .clk (clk),
        .num (work.sat_num),
        .div (work.sat_div),
        .quo (sat_quo)
    );

    assign res.hue        = hue_quo;
    assign res.saturation = PCT_W'(sat_quo);
    assign res.brightness = bright_reg[LAT-1];

endmodule

[hdl/rgb_to_hsv_convert_unit.sv]
// RGB to HSV converter: 8-bit pixel in, hue in degrees, saturation and value in percent out.
// Pixels pass the front register, middle queue, dividers and result queue, one per cycle unless stalled.
// The rate is set by the two 9-stage divider pipelines, which take a new division each cycle.
// Issue into the dividers reserves a result queue slot, so a stalled output never drops a beat.
// Reset is asynchronous and active low; it empties both queues and all pipeline stages.
// Depends on rhc_pkg, rhc_fifo, rhc_front, rhc_div_pipe and rhc_back.
module rgb_to_hsv_convert_unit #(
    parameter int MID_DEPTH = rhc_pkg::MID_DEPTH,
    parameter int OUT_DEPTH = rhc_pkg::OUT_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [rhc_pkg::CH_W-1:0]  red,
    input  logic [rhc_pkg::CH_W-1:0]  green,
    input  logic [rhc_pkg::CH_W-1:0]  blue,
    output logic                      empty,
    input  logic                      pop,
    output logic [rhc_pkg::HUE_W-1:0] hue,
    output logic [rhc_pkg::PCT_W-1:0] saturation,
    output logic [rhc_pkg::PCT_W-1:0] brightness
);

    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    logic                     front_valid;
    rhc_pkg::rhc_work_t       front_work;
    logic                     mid_full;
    logic                     mid_empty;
    logic                     mid_pop;
    rhc_pkg::rhc_work_t       mid_work;
    logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
    logic                     res_push;
    rhc_pkg::rhc_result_t     res_in;
    rhc_pkg::rhc_result_t     res_out;
    logic                     out_full;
    logic [OUT_CNT_W-1:0]     out_count;

    // Front end: classification stage.
    rhc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .work_valid (front_valid),
        .work       (front_work),
        .work_full  (mid_full)
    );

    // Queue between front and back.
    rhc_fifo #(
        .WIDTH ($bits(rhc_pkg::rhc_work_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_valid),
        .wdata (front_work),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_work),
        .empty (mid_empty),
        .count (mid_count)
    );

    // Back end: divider pipelines.
    rhc_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_empty (mid_empty),
        .work       (mid_work),
        .work_pop   (mid_pop),
        .out_count  (out_count),
        .res_push   (res_push),
        .res        (res_in)
    );

    // Result queue seen by the consumer.
    rhc_fifo #(
        .WIDTH ($bits(rhc_pkg::rhc_result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (out_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty),
        .count (out_count)
    );

    assign hue        = res_out.hue;
    assign saturation = res_out.saturation;
    assign brightness = res_out.brightness;

`ifndef SYNTHESIS
    // A beat leaving the dividers always finds room in the result queue.
    assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !out_full)
        else $error("result beat pushed into a full result queue");

    // The middle queue never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        mid_count <= ($clog2(MID_DEPTH+1))'(MID_DEPTH))
        else $error("middle queue count beyond its depth");

    // Every shown result lies in its legal range.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (hue <= 9'd359 && saturation <= 7'd100 && brightness <= 7'd100))
        else $error("result field out of range");
`endif

endmodule

[tb/tb_rgb_to_hsv_convert_unit.sv]
// Self-checking testbench for rgb_to_hsv_convert_unit: pixels go in, HSV beats come out.
// An integer HSV predictor fills a queue of expected beats that each output beat is checked against.
// Depends on rhc_pkg and the rgb_to_hsv_convert_unit RTL only.
`timescale 1ns / 100ps

module tb_rgb_to_hsv_convert_unit;

    localparam int STALL_LIMIT   = 5000;
    localparam int TAIL_CYCLES   = 30;
    localparam int HOLD_OFF_LEN  = 300;

    typedef struct packed {
        bit [rhc_pkg::CH_W-1:0] r;
        bit [rhc_pkg::CH_W-1:0] g;
        bit [rhc_pkg::CH_W-1:0] b;
    } pixel_t;

    logic                      clk;
    logic                      rst_n;
    logic                      push;
    logic                      full;
    logic [rhc_pkg::CH_W-1:0]  red;
    logic [rhc_pkg::CH_W-1:0]  green;
    logic [rhc_pkg::CH_W-1:0]  blue;
    logic                      empty;
    logic                      pop;
    logic [rhc_pkg::HUE_W-1:0] hue;
    logic [rhc_pkg::PCT_W-1:0] saturation;
    logic [rhc_pkg::PCT_W-1:0] brightness;

    // Expected HSV beats, oldest first.
    rhc_pkg::rhc_result_t pending_hsv[$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_req;
    int hold_left;
    int pixels_sent;
    int results_checked;
    int mismatches;
    int full_stalls;
    int quiet_cycles;

    rgb_to_hsv_convert_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .empty      (empty),
        .pop        (pop),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Integer HSV of one pixel with truncating division.
    function automatic rhc_pkg::rhc_result_t hsv_of_pixel(input pixel_t px);
        int rv;
        int gv;
        int bv;
        int mx;
        int mn;
        int d;
        int num;
        rhc_pkg::rhc_result_t res;
        begin
            rv  = px.r;
            gv  = px.g;
            bv  = px.b;
            mx  = (rv > gv) ? rv : gv;
            mx  = (mx > bv) ? mx : bv;
            mn  = (rv < gv) ? rv : gv;
            mn  = (mn < bv) ? mn : bv;
            d   = mx - mn;
            res = '0;
            if (mx != 0)
            begin
                res.brightness = rhc_pkg::PCT_W'((100 * mx) / 255);
                res.saturation = rhc_pkg::PCT_W'((100 * d) / mx);
                if (d != 0)
                begin
                    // Red wins a tie for the maximum, then green.
                    if (rv == mx)
                        num = 60 * (gv - bv);
                    else if (gv == mx)
                        num = 120 * d + 60 * (bv - rv);
                    else
                        num = 240 * d + 60 * (rv - gv);
                    if (num < 0)
                        num += 360 * d;
                    res.hue = rhc_pkg::HUE_W'(num / d);
                end
            end
            return res;
        end
    endfunction

    // Random pixel, biased toward grey levels, ties and the ends of the range.
    function automatic pixel_t random_pixel();
        pixel_t px;
        int     hi;
        int     lo;
        begin
            px.r = 8'($urandom);
            px.g = 8'($urandom);
            px.b = 8'($urandom);
            hi   = $urandom_range(1, 255);
            lo   = $urandom_range(0, hi - 1);
            case ($urandom_range(0, 9))
                5:
                begin
                    px.g = px.r;
                    px.b = px.r;
                end
                6:
                begin
                    // Two channels share the maximum.
                    case ($urandom_range(0, 2))
                        0: px = '{8'(hi), 8'(hi), 8'(lo)};
                        1: px = '{8'(lo), 8'(hi), 8'(hi)};
                        default: px = '{8'(hi), 8'(lo), 8'(hi)};
                    endcase
                end
                7:
                begin
                    px.g = 8'(px.r ^ $urandom_range(0, 1));
                    px.b = 8'(px.r ^ $urandom_range(0, 3));
                end
                8:
                begin
                    px.r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    px.b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end
                9:
                begin
                    px.r = 8'($urandom_range(0, 3));
                    px.g = 8'($urandom_range(0, 3));
                    px.b = 8'($urandom_range(0, 3));
                end
                default:
                begin
                end
            endcase
            return px;
        end
    endfunction

    // Offers one pixel, after a random idle gap when allowed, and holds it until it is taken.
    // Called just after a falling edge; returns just after a falling edge with push still high.
    task automatic send_pixel(input pixel_t px, input bit may_idle);
        bit taken;
        begin
            if (may_idle && $urandom_range(0, 99) < send_idle_pct)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            push  <= 1'b1;
            red   <= px.r;
            green <= px.g;
            blue  <= px.b;
            taken = 1'b0;
            while (!taken)
            begin
                @(posedge clk);
                if (full)
                    full_stalls++;
                else
                begin
                    taken = 1'b1;
                    pending_hsv.push_back(hsv_of_pixel(px));
                    pixels_sent++;
                end
                @(negedge clk);
            end
        end
    endtask

    // Stops offering and waits until every expected beat has come out.
    task automatic wait_for_drain();
        begin
            push <= 1'b0;
            while (pending_hsv.size() != 0)
                @(negedge clk);
        end
    endtask

    // Extremes, every sector, grey and black pixels, ties and the negative hue wrap.
    task automatic test_directed_pixels();
        pixel_t cases[$];
        begin
            cases = '{
                '{8'd0,   8'd0,   8'd0},   '{8'd255, 8'd255, 8'd255},
                '{8'd1,   8'd1,   8'd1},   '{8'd128, 8'd128, 8'd128},
                '{8'd255, 8'd0,   8'd0},   '{8'd0,   8'd255, 8'd0},
                '{8'd0,   8'd0,   8'd255}, '{8'd255, 8'd255, 8'd0},
                '{8'd0,   8'd255, 8'd255}, '{8'd255, 8'd0,   8'd255},
                '{8'd255, 8'd0,   8'd1},   '{8'd255, 8'd1,   8'd0},
                '{8'd1,   8'd0,   8'd0},   '{8'd0,   8'd0,   8'd1},
                '{8'd0,   8'd1,   8'd0},   '{8'd254, 8'd255, 8'd255},
                '{8'd255, 8'd254, 8'd254}, '{8'd170, 8'd85,  8'd0},
                '{8'd85,  8'd170, 8'd255}, '{8'd200, 8'd10,  8'd100},
                '{8'd10,  8'd200, 8'd100}, '{8'd1,   8'd255, 8'd0}
            };
            foreach (cases[i])
                send_pixel(cases[i], 1'b1);
            wait_for_drain();
        end
    endtask

    // A random stream under one mix of sender and receiver idling.
    task automatic test_random_stream(input int count, input int send_pct, input int recv_pct);
        begin
            send_idle_pct = send_pct;
            recv_idle_pct = recv_pct;
            repeat (count)
                send_pixel(random_pixel(), 1'b1);
            wait_for_drain();
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering beats.
    task automatic test_full_backpressure();
        begin
            hold_off_req = HOLD_OFF_LEN;
            repeat (60)
                send_pixel(random_pixel(), 1'b0);
            wait_for_drain();
        end
    endtask

    // The sender pauses mid-stream until the converter has fully drained.
    task automatic test_drain_pause();
        begin
            repeat (10)
                send_pixel(random_pixel(), 1'b0);
            wait_for_drain();
            repeat (10)
                send_pixel(random_pixel(), 1'b0);
            wait_for_drain();
        end
    endtask

    // Receiver side: random pop, or a counted hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_off_req != 0)
        begin
            hold_left    = hold_off_req;
            hold_off_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Checks each output beat against the oldest expected one.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_hsv.size() == 0)
            begin
                $display("%0t: unexpected beat hue=%0d saturation=%0d brightness=%0d",
                         $time, hue, saturation, brightness);
                mismatches++;
            end
            else
            begin
                if (hue !== pending_hsv[0].hue)
                begin
                    $display("%0t: hue expected %0d, actual %0d",
                             $time, pending_hsv[0].hue, hue);
                    mismatches++;
                end
                if (saturation !== pending_hsv[0].saturation)
                begin
                    $display("%0t: saturation expected %0d, actual %0d",
                             $time, pending_hsv[0].saturation, saturation);
                    mismatches++;
                end
                if (brightness !== pending_hsv[0].brightness)
                begin
                    $display("%0t: brightness expected %0d, actual %0d",
                             $time, pending_hsv[0].brightness, brightness);
                    mismatches++;
                end
                void'(pending_hsv.pop_front());
                results_checked++;
            end
        end
    end

    // Watchdog: ends the run after too many cycles in which no beat moves.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles, %0d still expected",
                     $time, STALL_LIMIT, pending_hsv.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n           = 1'b0;
        push            = 1'b0;
        pop             = 1'b0;
        red             = '0;
        green           = '0;
        blue            = '0;
        send_idle_pct   = 35;
        recv_idle_pct   = 50;
        hold_off_req    = 0;
        hold_left       = 0;
        pixels_sent     = 0;
        results_checked = 0;
        mismatches      = 0;
        full_stalls     = 0;
        quiet_cycles    = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_pixels();
        test_random_stream(160, 35, 50);
        test_full_backpressure();
        test_random_stream(140, 50, 35);
        test_drain_pause();
        test_random_stream(120, 0, 0);

        // Let any stray beat show up before the verdict.
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Sent %0d pixels (directed corners, biased random, long output hold-off,",
                 pixels_sent);
        $display("drain pause, three idle mixes): %0d beats checked, %0d input stalls seen.",
                 results_checked, full_stalls);
        if (mismatches == 0 && pending_hsv.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[files.f]
hdl/rhc_pkg.sv
hdl/rhc_fifo.sv
hdl/rhc_front.sv
hdl/rhc_div_pipe.sv
hdl/rhc_back.sv
hdl/rgb_to_hsv_convert_unit.sv
tb/tb_rgb_to_hsv_convert_unit.sv
